// ===== sv/skt_pkg.sv =====
package skt_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int OP_W = 2;
	localparam int KEY_W = 31;
	localparam int PAY_W = 8;
	localparam int POS_W = 5;
	localparam int COUNT_OUT_W = 6;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_LAST,
		ST_REM,
		ST_RD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] read_key;
		logic [PAY_W-1:0] read_payload;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
		logic             is_full;
	} res_t;

endpackage

// ===== sv/skt_engine.sv =====
module skt_engine
	import skt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic idle,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	entry_t mem [0:CAPACITY-1];
	entry_t rdata_q;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              found_q, found_d;
	req_t              req_q, req_d;
	logic              ok_q, ok_d;
	logic [KEY_W-1:0]  rkey_q, rkey_d;
	logic [PAY_W-1:0]  rpay_q, rpay_d;

	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;
	entry_t            new_ent;
	logic              key_lt;
	logic              key_eq;
	logic              hit;
	logic              pos_ok;

	// shared key comparator
	assign key_lt = rdata_q.key < req_q.key;
	assign key_eq = rdata_q.key == req_q.key;

	assign new_ent = '{key: req_q.key, payload: req_q.payload};
	assign hit = found_q || key_eq;
	assign pos_ok = (32'(req.position) < 32'(count_q)) && (32'(req.position) < CAPACITY);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		found_q <= found_d;
		req_q   <= req_d;
		ok_q    <= ok_d;
		rkey_q  <= rkey_d;
		rpay_q  <= rpay_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		found_d   = found_q;
		req_d     = req_q;
		ok_d      = ok_q;
		rkey_d    = rkey_q;
		rpay_d    = rpay_q;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = rdata_q;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_d   = req;
					ok_d    = 1'b0;
					rkey_d  = '0;
					rpay_d  = '0;
					found_d = 1'b0;
					unique case (req.op)
						OP_INSERT: begin
							if (count_q >= CNT_W'(CAPACITY)) begin
								state_d = ST_DONE;
							end else if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = '{key: req.key, payload: req.payload};
								count_d = count_q + CNT_W'(1);
								ok_d    = 1'b1;
								state_d = ST_DONE;
							end else begin
								idx_d   = ADDR_W'(count_q - CNT_W'(1));
								rd_addr = idx_d;
								state_d = ST_INS;
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								state_d = ST_DONE;
							end else begin
								idx_d   = '0;
								rd_addr = '0;
								state_d = ST_REM;
							end
						end
						OP_READ: begin
							if (pos_ok) begin
								rd_addr = ADDR_W'(req.position);
								state_d = ST_RD;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			// walk down from the top, moving keys not below the new key up one slot
			ST_INS: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + ADDR_W'(1);
				if (key_lt) begin
					wr_data = new_ent;
					count_d = count_q + CNT_W'(1);
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end else begin
					wr_data = rdata_q;
					if (idx_q == '0) begin
						state_d = ST_INS_LAST;
					end else begin
						idx_d   = idx_q - ADDR_W'(1);
						rd_addr = idx_d;
					end
				end
			end
			ST_INS_LAST: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = new_ent;
				count_d = count_q + CNT_W'(1);
				ok_d    = 1'b1;
				state_d = ST_DONE;
			end
			// walk up, after the first match pull each entry down one slot
			ST_REM: begin
				if (found_q) begin
					wr_en   = 1'b1;
					wr_addr = idx_q - ADDR_W'(1);
					wr_data = rdata_q;
				end
				found_d = hit;
				if (CNT_W'(idx_q) == count_q - CNT_W'(1)) begin
					if (hit) begin
						count_d = count_q - CNT_W'(1);
						ok_d    = 1'b1;
					end
					state_d = ST_DONE;
				end else begin
					idx_d   = idx_q + ADDR_W'(1);
					rd_addr = idx_d;
				end
			end
			ST_RD: begin
				ok_d    = 1'b1;
				rkey_d  = rdata_q.key;
				rpay_d  = rdata_q.payload;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle = state_q == ST_IDLE;

	assign res.ok           = ok_q;
	assign res.read_key     = rkey_q;
	assign res.read_payload = rpay_q;
	assign res.entry_count  = count_q;
	assign res.is_empty     = count_q == '0;
	assign res.is_full      = count_q >= CNT_W'(CAPACITY);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_req_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> state_q == ST_IDLE)
		else $error("request while busy");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> CNT_W'(wr_addr) <= count_q)
		else $error("store write beyond filled part");

	a_ins_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> CNT_W'(idx_q) < count_q)
		else $error("insert walk index out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> state_q == ST_DONE && $stable(count_q))
		else $error("result dropped while stalled");

endmodule

// ===== sv/sorted_key_table.sv =====
// insert and remove walk the store before the result register is loaded;
// the walk reads one store entry per cycle
// throughput: one item at a time, the next item is taken once the walk is over
// and the output register has room
// reset clears the entry count, the engine state and the output valid flag; the store
// contents stay undefined and need no clearing pass
module sorted_key_table
	import skt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // key, payload, position, zero fill
	input  logic [OP_W-1:0]      s_axis_tuser,  // operation
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_key, read_payload, entry_count,
	                                            // is_empty, is_full, zero fill
	output logic [0:0]           m_axis_tuser   // ok
);

	req_t req;
	res_t res;
	logic req_valid;
	logic eng_idle;
	logic res_valid;
	logic res_ready;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                 out_ok_q;

	assign req.op       = s_axis_tuser;
	assign req.key      = s_axis_tdata[KEY_W-1:0];
	assign req.payload  = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
	assign req.position = s_axis_tdata[KEY_W+PAY_W+POS_W-1:KEY_W+PAY_W];

	assign s_axis_tready = eng_idle;
	assign req_valid = s_axis_tvalid && eng_idle;
	assign res_ready = !out_valid_q || m_axis_tready;

	skt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_ok_q   <= res.ok;
			out_data_q <= M_TDATA_W'({res.is_full, res.is_empty,
				COUNT_OUT_W'(res.entry_count), res.read_payload, res.read_key});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ok_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	import skt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int FILL_W = S_TDATA_W - KEY_W - PAY_W - POS_W;
	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_ITEMS = 150;
	localparam int TAIL_CYCLES = CAPACITY + 8;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	typedef struct packed {
		logic                   ok;
		logic [KEY_W-1:0]       read_key;
		logic [PAY_W-1:0]       read_payload;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   is_empty;
		logic                   is_full;
	} status_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [OP_W-1:0]      s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]           m_axis_tuser;

	// shadow copy of the table
	logic [KEY_W-1:0] table_key [CAPACITY];
	logic [PAY_W-1:0] table_payload [CAPACITY];
	int               table_count = 0;

	status_t expected_status [$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      cycles = 0;
	bit      idle_en = 1'b1;
	bit      hold_go = 1'b0;
	int      hold_left = 0;
	int      stall_left = 0;

	int n_items = 0, n_ins = 0, n_ins_full = 0, n_rem = 0, n_rem_hit = 0;
	int n_rd = 0, n_rd_hit = 0, n_bad_op = 0, peak_count = 0, n_filled = 0;

	sorted_key_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_status.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic status_t update_table(input logic [OP_W-1:0] op,
		input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
		status_t r;
		int slot;
		int i;
		r = '0;
		slot = 0;
		case (op)
			OP_INSERT: begin
				if (table_count < CAPACITY) begin
					while (slot < table_count && table_key[slot] < k)
						slot++;
					for (i = table_count; i > slot; i--) begin
						table_key[i] = table_key[i-1];
						table_payload[i] = table_payload[i-1];
					end
					table_key[slot] = k;
					table_payload[slot] = p;
					table_count++;
					r.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				while (slot < table_count && table_key[slot] != k)
					slot++;
				if (slot < table_count) begin
					for (i = slot; i + 1 < table_count; i++) begin
						table_key[i] = table_key[i+1];
						table_payload[i] = table_payload[i+1];
					end
					table_count--;
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (pos < table_count) begin
					r.ok = 1'b1;
					r.read_key = table_key[pos];
					r.read_payload = table_payload[pos];
				end
			end
			default: ;
		endcase
		r.entry_count = table_count[COUNT_OUT_W-1:0];
		r.is_empty = (table_count == 0);
		r.is_full = (table_count >= CAPACITY);
		return r;
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
		input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
		status_t r;
		bit was_full;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{FILL_W{1'b0}}, pos, p, k};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		was_full = (table_count >= CAPACITY);
		r = update_table(op, k, p, pos);
		expected_status.push_back(r);
		n_items++;
		case (op)
			OP_INSERT: begin
				n_ins++;
				if (was_full)
					n_ins_full++;
				else if (r.is_full)
					n_filled++;
			end
			OP_REMOVE: begin
				n_rem++;
				n_rem_hit += int'(r.ok);
			end
			OP_READ: begin
				n_rd++;
				n_rd_hit += int'(r.ok);
			end
			default: n_bad_op++;
		endcase
		if (table_count > peak_count)
			peak_count = table_count;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return KEY_W'($urandom_range(0, 40));
			5, 6: return KEY_MAX - KEY_W'($urandom_range(0, 40));
			default: return KEY_W'($urandom());
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] stored_key();
		if (table_count == 0)
			return pick_key();
		return table_key[$urandom_range(0, table_count - 1)];
	endfunction

	// receiver: long hold on request, otherwise short random stalls while idle_en is set
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic note_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result %0d, %s: expected %0h, got %0h",
				results_seen, field, want, got);
	endtask

	always @(posedge clk) begin
		status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d, tdata %0h", results_seen, m_axis_tdata);
			end else begin
				want = expected_status.pop_front();
				if (m_axis_tuser[0] !== want.ok)
					note_mismatch("ok", 32'(want.ok), 32'(m_axis_tuser[0]));
				if (m_axis_tdata[30:0] !== want.read_key)
					note_mismatch("read_key", 32'(want.read_key), 32'(m_axis_tdata[30:0]));
				if (m_axis_tdata[38:31] !== want.read_payload)
					note_mismatch("read_payload", 32'(want.read_payload),
						32'(m_axis_tdata[38:31]));
				if (m_axis_tdata[44:39] !== want.entry_count)
					note_mismatch("entry_count", 32'(want.entry_count),
						32'(m_axis_tdata[44:39]));
				if (m_axis_tdata[45] !== want.is_empty)
					note_mismatch("is_empty", 32'(want.is_empty), 32'(m_axis_tdata[45]));
				if (m_axis_tdata[46] !== want.is_full)
					note_mismatch("is_full", 32'(want.is_full), 32'(m_axis_tdata[46]));
			end
			results_seen++;
		end
	end

	task automatic test_directed();
		int i;
		send_item(OP_READ, '0, '0, '0);
		send_item(OP_REMOVE, KEY_W'(5), '0, '0);
		send_item(OP_UNUSED, KEY_MAX, 8'hff, 5'h1f);
		send_item(OP_INSERT, KEY_MAX, 8'hff, '0);
		send_item(OP_INSERT, '0, '0, 5'h1f);
		send_item(OP_INSERT, KEY_W'(100), 8'ha5, '0);
		send_item(OP_INSERT, KEY_W'(100), 8'h5a, '0);
		send_item(OP_INSERT, KEY_W'(50), 8'h01, '0);
		for (i = 0; i < 6; i++)
			send_item(OP_READ, '0, '0, POS_W'(i));
		send_item(OP_READ, KEY_MAX, 8'hff, 5'h1f);
		send_item(OP_REMOVE, KEY_W'(77), '0, '0);
		send_item(OP_REMOVE, KEY_W'(100), '0, '0);
		send_item(OP_READ, '0, '0, POS_W'(2));
		send_item(OP_UNUSED, '0, '0, '0);
		send_item(OP_REMOVE, KEY_MAX, '0, '0);
		send_item(OP_REMOVE, '0, '0, '0);
		send_item(OP_REMOVE, KEY_W'(50), '0, '0);
		send_item(OP_REMOVE, KEY_W'(100), '0, '0);
		send_item(OP_READ, '0, '0, '0);
	endtask

	task automatic test_full_table();
		while (table_count < CAPACITY)
			send_item(OP_INSERT, pick_key(), 8'($urandom()), '0);
		send_item(OP_INSERT, KEY_W'(3), 8'h3c, '0);
		send_item(OP_INSERT, KEY_MAX, 8'hc3, '0);
		send_item(OP_READ, '0, '0, 5'h1f);
		send_item(OP_READ, '0, '0, '0);
		send_item(OP_UNUSED, KEY_MAX, 8'hff, 5'h1f);
		while (table_count > 0)
			send_item(OP_REMOVE, stored_key(), '0, '0);
		send_item(OP_REMOVE, KEY_W'(3), '0, '0);
	endtask

	task automatic test_backpressure();
		int i;
		wait_drained();
		hold_go = 1'b1;
		for (i = 0; i < 12; i++)
			send_item(i % 3 == 2 ? OP_READ : OP_INSERT, pick_key(), 8'($urandom()),
				POS_W'(i));
		wait_drained();
		while (table_count > 0)
			send_item(OP_REMOVE, stored_key(), '0, '0);
	endtask

	task automatic test_random();
		int i;
		int roll;
		bit growing;
		logic [KEY_W-1:0] k;
		logic [POS_W-1:0] pos;
		growing = 1'b1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				idle_en = 1'b0;
			if (growing && table_count >= CAPACITY && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && table_count == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			roll = $urandom_range(0, 99);
			if (table_count > 0 && $urandom_range(0, 4) != 0)
				pos = POS_W'($urandom_range(0, table_count - 1));
			else
				pos = POS_W'($urandom());
			if (roll < 2) begin
				send_item(OP_UNUSED, KEY_W'($urandom()), 8'($urandom()), POS_W'($urandom()));
			end else if (roll < 15) begin
				send_item(OP_READ, KEY_W'($urandom()), 8'($urandom()), pos);
			end else if ((roll < 85) == growing) begin
				send_item(OP_INSERT, pick_key(), 8'($urandom()), POS_W'($urandom()));
			end else begin
				case ($urandom_range(0, 6))
					0, 1, 2, 3: k = stored_key();
					4, 5: k = pick_key();
					default: k = KEY_W'($urandom());
				endcase
				send_item(OP_REMOVE, k, 8'($urandom()), POS_W'($urandom()));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d items: %0d inserts (%0d refused on a full table), %0d removes (%0d hits),",
			n_items, n_ins, n_ins_full, n_rem, n_rem_hit);
		$display("%0d reads (%0d in range), %0d unused ops; table filled %0d times, peak %0d",
			n_rd, n_rd_hit, n_bad_op, n_filled, peak_count);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sorted_key_table.f =====
sv/skt_pkg.sv
sv/skt_engine.sv
sv/sorted_key_table.sv
tb/tb.sv
